// ----- rtl/sdee_pkg.sv -----
`timescale 1ns / 1ps

package sdee_pkg;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [14:0] MAG_LIMIT  = 15'd3277;
  localparam logic [17:0] MAG10_EDGE = 18'd32750;
  localparam logic [3:0]  DIGIT_EDGE = 4'd7;

  localparam logic [15:0] DIV10_RECIP = 16'hcccd;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [1:0] ERASE_SPACE_STEP = 2'd1;
  localparam logic [1:0] ERASE_LAST_STEP  = 2'd2;

  typedef enum logic [2:0] {
    JOB_ECHO  = 3'b001,
    JOB_ERASE = 3'b010,
    JOB_VALUE = 3'b100
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  ch;
    logic [15:0] val;
  } job_t;

endpackage

// ----- rtl/signed_decimal_entry_editor_unit.sv -----
`timescale 1ns / 1ps

// Signed decimal entry editor. Takes one terminal character per char_valid/char_stall
// transaction and answers on the result channel: one echo transaction for an accepted
// digit or minus sign, three (backspace, space, backspace) for an erase, and one
// value transaction (kind = 1) on CR or LF. Ignored characters produce no transaction.
// The entry state is updated in the cycle the character is taken; results drain from
// a two-entry job queue at one transaction per cycle while result_stall is low. A new
// character is taken whenever the second queue slot is free, even while results are
// stalled.
module signed_decimal_entry_editor_unit
  import sdee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               kind,
  output logic [7:0]         echo_char,
  output logic signed [15:0] value,
  output logic               last
);

  logic [14:0] magnitude, magnitude_next;
  logic        negative, negative_next;

  job_t        cur_job, nxt_job, push_job;
  logic        cur_valid, nxt_valid;
  logic [1:0]  step;

  logic        take;
  logic        push;
  logic        cur_done;
  logic        out_take;

  logic [3:0]  digit;
  logic        is_digit;
  logic [17:0] mag10;
  logic [30:0] div_prod;
  logic [14:0] mag_div10;

  assign char_stall = nxt_valid;
  assign take       = char_valid && !nxt_valid;

  assign digit     = char_in[3:0];
  assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign mag10     = {magnitude, 3'b000} + {2'b00, magnitude, 1'b0};
  assign div_prod  = {1'b0, magnitude} * {15'd0, DIV10_RECIP};
  assign mag_div10 = 15'(div_prod >> DIV10_SHIFT);

  always_comb begin
    magnitude_next = magnitude;
    negative_next  = negative;
    push           = 1'b0;
    push_job.kind  = JOB_ECHO;
    push_job.ch    = char_in;
    push_job.val   = 16'd0;
    if (is_digit) begin
      if (magnitude == 15'd0 && digit != 4'd0) begin
        magnitude_next = {11'd0, digit};
        push           = 1'b1;
      end else if (magnitude < MAG_LIMIT) begin
        if (!((mag10 > MAG10_EDGE) && (digit > DIGIT_EDGE))) begin
          magnitude_next = 15'(mag10 + {14'd0, digit});
          push           = 1'b1;
        end
      end
    end else if (char_in == CH_DEL || char_in == CH_BS) begin
      push_job.kind = JOB_ERASE;
      if (magnitude != 15'd0) begin
        magnitude_next = mag_div10;
        push           = 1'b1;
      end else if (negative) begin
        negative_next = 1'b0;
        push          = 1'b1;
      end
    end else if (char_in == CH_MINUS) begin
      if (magnitude == 15'd0) begin
        negative_next = 1'b1;
        push          = 1'b1;
      end
    end else if (char_in == CH_CR || char_in == CH_LF) begin
      push_job.kind  = JOB_VALUE;
      push_job.val   = negative ? 16'(17'h10000 - {2'b00, magnitude})
                                : {1'b0, magnitude};
      magnitude_next = 15'd0;
      negative_next  = 1'b0;
      push           = 1'b1;
    end
  end

  always_comb begin
    result_valid = cur_valid;
    kind         = (cur_job.kind == JOB_VALUE);
    echo_char    = 8'd0;
    value        = 16'sd0;
    last         = 1'b1;
    case (cur_job.kind)
      JOB_ECHO:  echo_char = cur_job.ch;
      JOB_ERASE: begin
        echo_char = (step == ERASE_SPACE_STEP) ? CH_SPACE : CH_BS;
        last      = (step == ERASE_LAST_STEP);
      end
      JOB_VALUE: value = signed'(cur_job.val);
      default:   echo_char = 8'd0;
    endcase
  end

  assign out_take = cur_valid && !result_stall;
  assign cur_done = out_take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude <= 15'd0;
      negative  <= 1'b0;
      cur_valid <= 1'b0;
      nxt_valid <= 1'b0;
      step      <= 2'd0;
    end else begin
      if (take) begin
        magnitude <= magnitude_next;
        negative  <= negative_next;
      end
      if (cur_done) begin
        step <= 2'd0;
        if (nxt_valid) begin
          cur_job   <= nxt_job;
          nxt_valid <= take && push;
          nxt_job   <= push_job;
        end else begin
          cur_valid <= take && push;
          cur_job   <= push_job;
        end
      end else begin
        if (out_take) begin
          step <= step + 2'd1;
        end
        if (take && push) begin
          if (cur_valid) begin
            nxt_valid <= 1'b1;
            nxt_job   <= push_job;
          end else begin
            cur_valid <= 1'b1;
            cur_job   <= push_job;
            step      <= 2'd0;
          end
        end
      end
    end
  end

endmodule
